// File: src/mmp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmp_pkg
// Shared types and constants of the modular matrix power block.
// ----------------------------------------------------------------------------
package mmp_pkg;

    localparam int MAX_DIM = 4;
    localparam int IDX_W   = 2;
    localparam int CELLS   = MAX_DIM * MAX_DIM;
    localparam int CELL_W  = 2 * IDX_W;
    localparam int BANK_W  = 2;
    localparam int ADDR_W  = BANK_W + CELL_W;
    localparam int VAL_W   = 31;
    localparam int EXP_W   = 63;
    localparam int DIM_W   = 3;
    localparam int STEP_W  = 5;

    localparam logic [VAL_W-1:0] MODULUS_RESET = 31'd1000000007;
    localparam logic [DIM_W-1:0] DIM_RESET     = 3'd4;

    localparam logic REG_MODULUS = 1'b0;
    localparam logic REG_DIM     = 1'b1;

    typedef enum logic [BANK_W-1:0] {
        BANK_BASE = 2'd0,
        BANK_POW  = 2'd1,
        BANK_SQ   = 2'd2,
        BANK_TMP  = 2'd3
    } bank_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD_RED,
        S_INIT_POW,
        S_CP_RD,
        S_CP_WR,
        S_STEP,
        S_MM_RDA,
        S_MM_RDB,
        S_MM_MUL,
        S_MM_WAIT,
        S_OUT_RD,
        S_OUT_WR
    } state_t;

    typedef struct packed {
        logic             start;
        logic [VAL_W-1:0] a;
        logic [VAL_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic             done;
        logic [VAL_W-1:0] value;
    } mul_rsp_t;

endpackage
`default_nettype wire

// File: src/mmp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmp_if
// Channel interfaces: configuration writes, matrix loads and results.
// ----------------------------------------------------------------------------
interface mmp_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [30:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

interface mmp_load_if;
    logic        valid;
    logic        ready;
    logic [1:0]  row_index;
    logic [1:0]  col_index;
    logic [30:0] entry_value;
    logic [62:0] exponent;
    logic        last_entry;
    modport source (output valid, output row_index, output col_index,
                    output entry_value, output exponent, output last_entry,
                    input ready);
    modport sink   (input valid, input row_index, input col_index,
                    input entry_value, input exponent, input last_entry,
                    output ready);
endinterface

interface mmp_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  out_row;
    logic [1:0]  out_col;
    logic [30:0] out_value;
    logic        last_result;
    modport source (output valid, output out_row, output out_col,
                    output out_value, output last_result, input ready);
    modport sink   (input valid, input out_row, input out_col,
                    input out_value, input last_result, output ready);
endinterface
`default_nettype wire

// File: src/mmp_mulmod.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmp_mulmod
// Bit-serial modular multiplier: reduces b modulo m one bit a cycle, then
// forms a*b modulo m by shift-and-add, MSB of a first.
// ----------------------------------------------------------------------------
module mmp_mulmod (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire mmp_pkg::mul_req_t  req,
    input  wire logic [30:0]        m,
    output mmp_pkg::mul_rsp_t       rsp
);
    import mmp_pkg::*;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(VAL_W - 1);

    logic              busy_reg, busy_next;
    logic              phase_reg, phase_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [VAL_W-1:0]  a_reg, a_next;
    logic [VAL_W-1:0]  b_reg, b_next;
    logic [VAL_W-1:0]  r_reg, r_next;
    logic [VAL_W-1:0]  acc_reg, acc_next;

    logic [VAL_W:0]    red_t;
    logic [VAL_W+1:0]  mul_t0, mul_t1, mul_t2;

    always_comb
    begin
        red_t  = {r_reg, b_reg[VAL_W-1]};
        if (red_t >= {1'b0, m})
        begin
            red_t = red_t - {1'b0, m};
        end
        mul_t0 = {1'b0, acc_reg, 1'b0} + (a_reg[VAL_W-1] ? {2'b00, r_reg} : '0);
        mul_t1 = (mul_t0 >= {2'b00, m}) ? mul_t0 - {2'b00, m} : mul_t0;
        mul_t2 = (mul_t1 >= {2'b00, m}) ? mul_t1 - {2'b00, m} : mul_t1;

        busy_next  = busy_reg;
        phase_next = phase_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        r_next     = r_reg;
        acc_next   = acc_reg;

        if (!busy_reg)
        begin
            if (req.start)
            begin
                busy_next  = 1'b1;
                phase_next = 1'b0;
                cnt_next   = '0;
                a_next     = req.a;
                b_next     = req.b;
                r_next     = '0;
                acc_next   = '0;
            end
        end
        else if (!phase_reg)
        begin
            // reduce b one bit a step
            r_next   = red_t[VAL_W-1:0];
            b_next   = {b_reg[VAL_W-2:0], 1'b0};
            cnt_next = cnt_reg + STEP_W'(1);
            if (cnt_reg == LAST_STEP)
            begin
                phase_next = 1'b1;
                cnt_next   = '0;
            end
        end
        else
        begin
            acc_next = mul_t2[VAL_W-1:0];
            a_next   = {a_reg[VAL_W-2:0], 1'b0};
            cnt_next = cnt_reg + STEP_W'(1);
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            phase_reg <= 1'b0;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            phase_reg <= phase_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        r_reg   <= r_next;
        acc_reg <= acc_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.value = acc_reg;

endmodule
`default_nettype wire

// File: src/modular_matrix_power.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// modular_matrix_power
// Modular matrix exponentiation by square-and-multiply over one scratch RAM.
// ----------------------------------------------------------------------------
//  channel  dir  carries                                          request
//  cfg      in   index (0 modulus, 1 dim_in_use), data            one write
//  load     in   row_index, col_index, entry_value, exponent,     one entry
//                last_entry
//  result   out  out_row, out_col, out_value, last_result         one entry
//
//  A load request passes the entry through the serial multiplier, which
//  reduces it modulo the modulus. The last entry then starts setup (an
//  identity matrix and a copy of the loaded one), then per exponent bit
//  one or two matrix products of n*n*n serial multiplies plus a copy
//  each. The serial multiplier and the one RAM read port set the pace.
//  Reset clears control state and the config registers; the RAM needs no clearing.
//  A stalled result holds in the output register; the next load is taken
//  while the final result still waits.
// ----------------------------------------------------------------------------
module modular_matrix_power (
    input  wire logic  clk,
    input  wire logic  rst_n,
    mmp_cfg_if.sink    cfg,
    mmp_load_if.sink   load,
    mmp_result_if.source result
);
    import mmp_pkg::*;

    localparam logic [CELL_W-1:0] CELL_LAST = CELL_W'(CELLS - 1);

    state_t            state_reg, state_next;
    logic [VAL_W-1:0]  mod_reg, mod_next;
    logic [DIM_W-1:0]  dim_reg, dim_next;
    logic [EXP_W-1:0]  exp_reg, exp_next;
    logic              did_mul_reg, did_mul_next;
    logic              init_cp_reg, init_cp_next;
    logic              last_reg, last_next;
    logic [IDX_W-1:0]  row_reg, row_next;
    logic [IDX_W-1:0]  col_reg, col_next;
    logic [IDX_W-1:0]  i_reg, i_next;
    logic [IDX_W-1:0]  j_reg, j_next;
    logic [IDX_W-1:0]  k_reg, k_next;
    logic [CELL_W-1:0] cp_reg, cp_next;
    logic [VAL_W-1:0]  sum_reg, sum_next;
    logic [VAL_W-1:0]  aval_reg, aval_next;
    bank_t             src_reg, src_next;
    bank_t             bsrc_reg, bsrc_next;
    bank_t             dst_reg, dst_next;

    logic              ovalid_reg, ovalid_next;
    logic [IDX_W-1:0]  orow_reg, orow_next;
    logic [IDX_W-1:0]  ocol_reg, ocol_next;
    logic [VAL_W-1:0]  oval_reg, oval_next;
    logic              olast_reg, olast_next;

    // scratch RAM: four banks of MAX_DIM x MAX_DIM entries
    logic [VAL_W-1:0]  mem [2**ADDR_W];
    logic [ADDR_W-1:0] rd_addr;
    logic [VAL_W-1:0]  rd_data_reg;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [VAL_W-1:0]  wr_data;

    mul_req_t          mreq;
    mul_rsp_t          mrsp;
    logic [VAL_W-1:0]  m_eff;
    logic [VAL_W-1:0]  one_val;
    logic [IDX_W-1:0]  n_last;
    logic [VAL_W:0]    acc_sum;
    logic [VAL_W-1:0]  sum_red;
    logic              out_free;

    mmp_mulmod u_mulmod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mreq),
        .m     (m_eff),
        .rsp   (mrsp)
    );

    // modulus below two acts as one; dimension clamps to 1..MAX_DIM
    assign m_eff   = (mod_reg < VAL_W'(2)) ? VAL_W'(1) : mod_reg;
    assign one_val = (m_eff == VAL_W'(1)) ? '0 : VAL_W'(1);
    always_comb
    begin
        if (dim_reg == '0)
        begin
            n_last = '0;
        end
        else if (dim_reg > DIM_W'(MAX_DIM))
        begin
            n_last = IDX_W'(MAX_DIM - 1);
        end
        else
        begin
            n_last = IDX_W'(dim_reg - DIM_W'(1));
        end
    end

    assign acc_sum  = {1'b0, sum_reg} + {1'b0, mrsp.value};
    assign sum_red  = (acc_sum >= {1'b0, m_eff}) ? VAL_W'(acc_sum - {1'b0, m_eff})
                                                 : acc_sum[VAL_W-1:0];
    assign out_free = !ovalid_reg || result.ready;

    assign cfg.ready  = 1'b1;
    assign load.ready = (state_reg == S_IDLE);

    always_comb
    begin
        mod_next = mod_reg;
        dim_next = dim_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_MODULUS: mod_next = cfg.data;
                REG_DIM:     dim_next = cfg.data[DIM_W-1:0];
                default:     mod_next = mod_reg;
            endcase
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        exp_next     = exp_reg;
        did_mul_next = did_mul_reg;
        init_cp_next = init_cp_reg;
        last_next    = last_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        k_next       = k_reg;
        cp_next      = cp_reg;
        sum_next     = sum_reg;
        aval_next    = aval_reg;
        src_next     = src_reg;
        bsrc_next    = bsrc_reg;
        dst_next     = dst_reg;
        ovalid_next  = ovalid_reg && !result.ready;
        orow_next    = orow_reg;
        ocol_next    = ocol_reg;
        oval_next    = oval_reg;
        olast_next   = olast_reg;
        rd_addr      = '0;
        wr_en        = 1'b0;
        wr_addr      = '0;
        wr_data      = '0;
        mreq.start   = 1'b0;
        mreq.a       = aval_reg;
        mreq.b       = rd_data_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (load.valid)
                begin
                    // reduce the entry as 1 * value modulo m
                    row_next   = load.row_index;
                    col_next   = load.col_index;
                    last_next  = load.last_entry;
                    exp_next   = load.exponent;
                    mreq.start = 1'b1;
                    mreq.a     = VAL_W'(1);
                    mreq.b     = load.entry_value;
                    state_next = S_LOAD_RED;
                end
            end
            S_LOAD_RED:
            begin
                if (mrsp.done)
                begin
                    wr_en   = 1'b1;
                    wr_addr = {BANK_BASE, row_reg, col_reg};
                    wr_data = mrsp.value;
                    cp_next = '0;
                    state_next = last_reg ? S_INIT_POW : S_IDLE;
                end
            end
            S_INIT_POW:
            begin
                wr_en   = 1'b1;
                wr_addr = {BANK_POW, cp_reg};
                wr_data = (cp_reg[CELL_W-1:IDX_W] == cp_reg[IDX_W-1:0] &&
                           cp_reg[IDX_W-1:0] <= n_last) ? one_val : '0;
                cp_next = cp_reg + CELL_W'(1);
                if (cp_reg == CELL_LAST)
                begin
                    // seed the running square with the loaded matrix
                    src_next     = BANK_BASE;
                    dst_next     = BANK_SQ;
                    init_cp_next = 1'b1;
                    did_mul_next = 1'b0;
                    state_next   = S_CP_RD;
                end
            end
            S_CP_RD:
            begin
                rd_addr    = {src_reg, cp_reg};
                state_next = S_CP_WR;
            end
            S_CP_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = {dst_reg, cp_reg};
                wr_data = rd_data_reg;
                cp_next = cp_reg + CELL_W'(1);
                state_next = S_CP_RD;
                if (cp_reg == CELL_LAST)
                begin
                    state_next = S_STEP;
                    if (init_cp_reg)
                    begin
                        init_cp_next = 1'b0;
                    end
                    else if (dst_reg == BANK_POW)
                    begin
                        did_mul_next = 1'b1;
                    end
                    else
                    begin
                        exp_next     = exp_reg >> 1;
                        did_mul_next = 1'b0;
                    end
                end
            end
            S_STEP:
            begin
                i_next   = '0;
                j_next   = '0;
                k_next   = '0;
                sum_next = '0;
                if (exp_reg == '0)
                begin
                    state_next = S_OUT_RD;
                end
                else
                begin
                    if (exp_reg[0] && !did_mul_reg)
                    begin
                        src_next  = BANK_POW;
                        bsrc_next = BANK_SQ;
                        dst_next  = BANK_POW;
                    end
                    else
                    begin
                        src_next  = BANK_SQ;
                        bsrc_next = BANK_SQ;
                        dst_next  = BANK_SQ;
                    end
                    state_next = S_MM_RDA;
                end
            end
            S_MM_RDA:
            begin
                rd_addr    = {src_reg, i_reg, k_reg};
                state_next = S_MM_RDB;
            end
            S_MM_RDB:
            begin
                rd_addr    = {bsrc_reg, k_reg, j_reg};
                aval_next  = rd_data_reg;
                state_next = S_MM_MUL;
            end
            S_MM_MUL:
            begin
                mreq.start = 1'b1;
                state_next = S_MM_WAIT;
            end
            S_MM_WAIT:
            begin
                if (mrsp.done)
                begin
                    state_next = S_MM_RDA;
                    if (k_reg == n_last)
                    begin
                        // products land in the spare bank, then copy back
                        wr_en    = 1'b1;
                        wr_addr  = {BANK_TMP, i_reg, j_reg};
                        wr_data  = sum_red;
                        sum_next = '0;
                        k_next   = '0;
                        if (j_reg == n_last)
                        begin
                            j_next = '0;
                            if (i_reg == n_last)
                            begin
                                src_next   = BANK_TMP;
                                cp_next    = '0;
                                state_next = S_CP_RD;
                            end
                            else
                            begin
                                i_next = i_reg + IDX_W'(1);
                            end
                        end
                        else
                        begin
                            j_next = j_reg + IDX_W'(1);
                        end
                    end
                    else
                    begin
                        sum_next = sum_red;
                        k_next   = k_reg + IDX_W'(1);
                    end
                end
            end
            S_OUT_RD:
            begin
                rd_addr    = {BANK_POW, i_reg, j_reg};
                state_next = S_OUT_WR;
            end
            S_OUT_WR:
            begin
                rd_addr = {BANK_POW, i_reg, j_reg};
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    orow_next   = i_reg;
                    ocol_next   = j_reg;
                    oval_next   = rd_data_reg;
                    olast_next  = (i_reg == n_last) && (j_reg == n_last);
                    state_next  = S_OUT_RD;
                    if (j_reg == n_last)
                    begin
                        j_next = '0;
                        i_next = i_reg + IDX_W'(1);
                        if (i_reg == n_last)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        j_next = j_reg + IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            mod_reg     <= MODULUS_RESET;
            dim_reg     <= DIM_RESET;
            exp_reg     <= '0;
            did_mul_reg <= 1'b0;
            init_cp_reg <= 1'b0;
            last_reg    <= 1'b0;
            ovalid_reg  <= 1'b0;
            i_reg       <= '0;
            j_reg       <= '0;
            k_reg       <= '0;
            cp_reg      <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            mod_reg     <= mod_next;
            dim_reg     <= dim_next;
            exp_reg     <= exp_next;
            did_mul_reg <= did_mul_next;
            init_cp_reg <= init_cp_next;
            last_reg    <= last_next;
            ovalid_reg  <= ovalid_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            k_reg       <= k_next;
            cp_reg      <= cp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg   <= row_next;
        col_reg   <= col_next;
        sum_reg   <= sum_next;
        aval_reg  <= aval_next;
        src_reg   <= src_next;
        bsrc_reg  <= bsrc_next;
        dst_reg   <= dst_next;
        orow_reg  <= orow_next;
        ocol_reg  <= ocol_next;
        oval_reg  <= oval_next;
        olast_reg <= olast_next;
    end

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign result.valid       = ovalid_reg;
    assign result.out_row     = orow_reg;
    assign result.out_col     = ocol_reg;
    assign result.out_value   = oval_reg;
    assign result.last_result = olast_reg;

endmodule
`default_nettype wire

// File: src/mmp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmp_checker
// Port-level checks of the modular matrix power block.
// ----------------------------------------------------------------------------
module mmp_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        cfg_valid,
    input wire logic        cfg_ready,
    input wire logic        cfg_index,
    input wire logic [30:0] cfg_data,
    input wire logic        load_valid,
    input wire logic        load_ready,
    input wire logic        load_last,
    input wire logic        res_valid,
    input wire logic        res_ready,
    input wire logic [1:0]  res_row,
    input wire logic [1:0]  res_col,
    input wire logic [30:0] res_value,
    input wire logic        res_last
);
    import mmp_pkg::*;

    logic [VAL_W-1:0] mod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_reg <= MODULUS_RESET;
        end
        else if (cfg_valid && cfg_ready && cfg_index == REG_MODULUS)
        begin
            mod_reg <= cfg_data;
        end
    end

    // hold a stalled result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_value))
        else $error("stalled result changed");

    // the final result sits on the diagonal
    a_last_diag: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_last |-> res_row == res_col)
        else $error("final result off the diagonal");

    // a last load starts a run and blocks further loads
    a_run_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        load_valid && load_ready && load_last |=> !load_ready)
        else $error("load accepted during a run");

    // every result is reduced
    a_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_value < mod_reg || res_value == '0))
        else $error("result not reduced");

endmodule

bind modular_matrix_power mmp_checker u_mmp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg.valid),
    .cfg_ready  (cfg.ready),
    .cfg_index  (cfg.index),
    .cfg_data   (cfg.data),
    .load_valid (load.valid),
    .load_ready (load.ready),
    .load_last  (load.last_entry),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .res_row    (result.out_row),
    .res_col    (result.out_col),
    .res_value  (result.out_value),
    .res_last   (result.last_result)
);
`default_nettype wire
